// ===== src/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue_unit.
package spq_pkg;

    // default depth and the cap on results of one traverse request
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    // request kinds
    localparam logic [1:0] REQ_ENQ   = 2'd0;
    localparam logic [1:0] REQ_DEQ   = 2'd1;
    localparam logic [1:0] REQ_TRAV  = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // one queue entry
    typedef struct packed {
        logic signed [15:0] prio;
        logic signed [31:0] value;
    } item_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;   // sorted insert of the new entry
        logic deq;   // shift toward the head
        logic rot;   // rotate by one, head wraps to the tail
    } cell_ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it to the incoming one.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,    // slot index below fill level
    input  logic       keep_left,   // left neighbor keeps its entry on insert
    input  item_t      new_item,
    input  item_t      left_item,
    input  item_t      right_item,
    output logic       keep,        // this slot stays put on insert
    output item_t      item
);

    item_t item_reg;
    item_t item_next;

    // equal priority stays ahead of the new entry, which keeps arrival order
    assign keep = occupied && ($signed(item_reg.prio) <= $signed(new_item.prio));
    assign item = item_reg;

    // next slot contents
    always_comb begin
        item_next = item_reg;
        if (ctrl.enq) begin
            if (!keep) begin
                item_next = keep_left ? new_item : left_item;
            end
        end else if (ctrl.deq || ctrl.rot) begin
            item_next = right_item;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

// ===== src/stable_priority_queue_unit.sv =====
// Enqueue, dequeue and query give their one result in the cycle after the request is taken.
// Throughput: one such request per cycle while the result side keeps up.
// Traverse: the chain rotates once per cycle over all CAPACITY slots while the result side
// keeps up, emitting one entry per cycle up to MAX_RESULTS; no request is taken until it ends.
// Reset (aresetn low, synchronous): fill level, traverse state and output valid clear;
// slot contents are not reset and are only read below the fill level.
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] out_value, [47:32] out_priority,
                                   // [52:48] entry_count, [55:53] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TRAV = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] emit_n_reg, emit_n_next;

    logic          mvalid_reg, mvalid_next;
    logic [1:0]    mstat_reg, mstat_next;
    item_t         mitem_reg, mitem_next;
    logic [4:0]    mcount_reg, mcount_next;
    logic          mlast_reg, mlast_next;

    cell_ctrl_t    ctrl;
    item_t         new_item;
    item_t         item_w  [CAPACITY];
    item_t         left_w  [CAPACITY];
    item_t         right_w [CAPACITY];
    logic          keep_w  [CAPACITY];
    logic          keepl_w [CAPACITY];
    logic          occ_w   [CAPACITY];

    logic          out_free;
    logic          out_load;
    logic          accept;
    logic          emit;
    logic [CW+4:0] count_ext;
    logic [CW:0]   step_inc;

    assign new_item.value = s_tdata[31:0];
    assign new_item.prio  = s_tdata[47:32];

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign emit     = (step_reg < emit_n_reg);
    assign step_inc = {1'b0, step_reg} + {{CW{1'b0}}, 1'b1};

    // cell chain: slot 0 is the head
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_w[i]  = new_item;
            assign keepl_w[i] = 1'b1;
        end else begin : g_body
            assign left_w[i]  = item_w[i-1];
            assign keepl_w[i] = keep_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_w[i] = item_w[0];
        end else begin : g_mid
            assign right_w[i] = item_w[i+1];
        end
        assign occ_w[i] = (CW'(i) < count_reg);

        spq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occ_w[i]),
            .keep_left  (keepl_w[i]),
            .new_item   (new_item),
            .left_item  (left_w[i]),
            .right_item (right_w[i]),
            .keep       (keep_w[i]),
            .item       (item_w[i])
        );
    end

    // request sequencing and result register loading
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        emit_n_next = emit_n_reg;
        ctrl        = '0;
        out_load    = 1'b0;
        mstat_next  = mstat_reg;
        mitem_next  = mitem_reg;
        mlast_next  = mlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_load   = 1'b1;
                    mstat_next = STAT_OK;
                    mitem_next = '0;
                    mlast_next = 1'b1;
                    case (s_tuser)
                        REQ_ENQ: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                mstat_next = STAT_FULL;
                            end else begin
                                ctrl.enq   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_DEQ: begin
                            if (count_reg == '0) begin
                                mstat_next = STAT_UNDERFLOW;
                            end else begin
                                ctrl.deq   = 1'b1;
                                mitem_next = item_w[0];
                                count_next = count_reg - 1'b1;
                            end
                        end
                        REQ_TRAV: begin
                            if (count_reg == '0) begin
                                mstat_next = STAT_EMPTY;
                            end else begin
                                // results come from the rotation pass
                                out_load   = 1'b0;
                                state_next = ST_TRAV;
                                step_next  = '0;
                                if (32'(count_reg) > MAX_RESULTS) begin
                                    emit_n_next = CW'(MAX_RESULTS);
                                end else begin
                                    emit_n_next = count_reg;
                                end
                            end
                        end
                        default: begin
                            // fill-level query: defaults already set
                        end
                    endcase
                end
            end
            ST_TRAV: begin
                // rotate only when the head can be emitted, or need not be
                if (!emit || out_free) begin
                    ctrl.rot = 1'b1;
                    if (emit) begin
                        out_load   = 1'b1;
                        mstat_next = STAT_OK;
                        mitem_next = item_w[0];
                        mlast_next = (step_inc == {1'b0, emit_n_reg});
                    end
                    step_next = step_inc[CW-1:0];
                    if (step_reg == CW'(CAPACITY - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_ext   = {5'b0, count_next};
    assign mcount_next = out_load ? count_ext[4:0] : mcount_reg;

    always_comb begin
        mvalid_next = mvalid_reg;
        if (out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            emit_n_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            emit_n_reg <= emit_n_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        mstat_reg  <= mstat_next;
        mitem_reg  <= mitem_next;
        mcount_reg <= mcount_next;
        mlast_reg  <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mstat_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {3'b0, mcount_reg, mitem_reg.prio, mitem_reg.value};

`ifndef SYNTHESIS
    // fill level never exceeds the chain length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill level above capacity");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

    // no request is taken during a traverse pass
    a_trav_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRAV) |-> !s_tready)
        else $error("request accepted during traverse");

    // an accepted enqueue with room grows the fill level by one
    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == REQ_ENQ) && (count_reg < CW'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow fill level");
`endif

endmodule

// ===== verif/tb_stable_priority_queue_unit.sv =====
// Self-checking testbench for stable_priority_queue_unit: predicts every result of each
// accepted request and compares it, field by field, with the result stream.
// Depends on spq_pkg and the stable_priority_queue_unit RTL.
module tb_stable_priority_queue_unit
    import spq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_TAIL   = 40;   // last requests are sent with no idling
    localparam int RAND_REQS   = 300;

    // one request as queued for the driver
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [15:0] prio;
        bit          hold;   // wait for every pending result before sending
    } queue_req_t;

    // one result as predicted
    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
        logic [15:0] prio;
        logic [4:0]  count;
        logic        last;
    } queue_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [31:0] item_value, [47:32] item_priority
    logic [1:0]  s_tuser  = '0;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // [31:0] out_value, [47:32] out_priority,
                                  // [52:48] entry_count
    logic [1:0]  m_tuser;         // [1:0] status
    logic        m_tlast;

    queue_req_t    req_pending[$];
    queue_result_t results_expected[$];
    int            results_due = 0;
    bit            stim_done = 1'b0;

    // predictor state: entries sorted by priority, head at index 0
    logic signed [31:0] model_value [CAPACITY_DEF];
    logic signed [15:0] model_prio  [CAPACITY_DEF];
    int                 model_count = 0;

    int fail_count     = 0;
    int reqs_accepted  = 0;
    int results_seen   = 0;
    int full_hits      = 0;
    int underflow_hits = 0;
    int cycle_count    = 0;
    int src_gap        = 0;
    int sink_stall     = 0;

    stable_priority_queue_unit #(.CAPACITY(CAPACITY_DEF)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    task automatic add_req(input logic [1:0] kind, input logic [31:0] value,
                           input logic [15:0] prio, input bit hold);
        queue_req_t rq;
        rq.kind  = kind;
        rq.value = value;
        rq.prio  = prio;
        rq.hold  = hold;
        req_pending.push_back(rq);
    endtask

    task automatic push_result(input logic [1:0] status, input logic [31:0] value,
                               input logic [15:0] prio, input logic last);
        queue_result_t r;
        r.status = status;
        r.value  = value;
        r.prio   = prio;
        r.count  = 5'(model_count);
        r.last   = last;
        results_expected.push_back(r);
    endtask

    // apply one request to the predictor and queue the results it causes
    task automatic predict_queue(input queue_req_t rq);
        int pos;
        logic signed [31:0] head_value;
        logic signed [15:0] head_prio;
        pos = 0;
        case (rq.kind)
            REQ_ENQ: begin
                if (model_count >= CAPACITY_DEF) begin
                    full_hits++;
                    push_result(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    // equal priorities go behind the ones already held
                    while (pos < model_count && model_prio[pos] <= $signed(rq.prio))
                        pos++;
                    for (int i = model_count; i > pos; i--) begin
                        model_value[i] = model_value[i-1];
                        model_prio[i]  = model_prio[i-1];
                    end
                    model_value[pos] = rq.value;
                    model_prio[pos]  = rq.prio;
                    model_count++;
                    push_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            REQ_DEQ: begin
                if (model_count == 0) begin
                    underflow_hits++;
                    push_result(STAT_UNDERFLOW, '0, '0, 1'b1);
                end else begin
                    head_value = model_value[0];
                    head_prio  = model_prio[0];
                    for (int i = 1; i < model_count; i++) begin
                        model_value[i-1] = model_value[i];
                        model_prio[i-1]  = model_prio[i];
                    end
                    model_count--;
                    push_result(STAT_OK, head_value, head_prio, 1'b1);
                end
            end
            REQ_TRAV: begin
                if (model_count == 0)
                    push_result(STAT_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < model_count && i < MAX_RESULTS; i++)
                        push_result(STAT_OK, model_value[i], model_prio[i],
                                    (i + 1 == model_count || i + 1 == MAX_RESULTS));
            end
            default: begin
                // is-empty query: only the fill level is reported
                push_result(STAT_OK, '0, '0, 1'b1);
            end
        endcase
    endtask

    // driver: request side from the pending queue, result side ready with stalls
    always @(posedge aclk) begin
        queue_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            // result side
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (req_pending.size() > CALM_TAIL && $urandom_range(0, 6) == 0)
                    sink_stall = $urandom_range(1, 15);
            end
            // request side: move on only once the current request is taken
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_pending.size() == 0) begin
                    s_tvalid  <= 1'b0;
                    stim_done <= 1'b1;
                end else if (req_pending[0].hold && (s_tvalid || results_due != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = req_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.prio, nxt.value};
                    s_tuser  <= nxt.kind;
                    if (req_pending.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 15);
                end
            end
        end
    end

    // monitor: check results against the oldest prediction, then predict new requests
    always @(posedge aclk) begin
        queue_result_t exp_r;
        queue_req_t    rq;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (results_expected.size() == 0) begin
                    $error("result with none expected: tdata %h tuser %0d tlast %0d",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    exp_r = results_expected.pop_front();
                    if (m_tuser !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== exp_r.value) begin
                        $error("out_value: expected %0d, actual %0d",
                               $signed(exp_r.value), $signed(m_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_tdata[47:32] !== exp_r.prio) begin
                        $error("out_priority: expected %0d, actual %0d",
                               $signed(exp_r.prio), $signed(m_tdata[47:32]));
                        fail_count++;
                    end
                    if (m_tdata[52:48] !== exp_r.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               exp_r.count, m_tdata[52:48]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $error("last: expected %0d, actual %0d", exp_r.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                reqs_accepted++;
                rq.kind  = s_tuser;
                rq.value = s_tdata[31:0];
                rq.prio  = s_tdata[47:32];
                rq.hold  = 1'b0;
                predict_queue(rq);
            end
        end
        results_due <= results_expected.size();
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int r;
        bit fill_phase;
        logic [1:0]  kind;
        logic [31:0] value;
        logic [15:0] prio;

        // empty queue corner cases
        add_req(REQ_DEQ,   32'h1234_5678, 16'h00FF, 1'b0);
        add_req(REQ_TRAV,  '0, '0, 1'b0);
        add_req(REQ_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        // field extremes, then equal priorities that must keep arrival order
        add_req(REQ_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        add_req(REQ_ENQ, 32'h8000_0000, 16'h8000, 1'b0);
        add_req(REQ_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_req(REQ_ENQ, 32'h0000_0000, 16'h0000, 1'b0);
        add_req(REQ_ENQ, 32'd11, 16'h0000, 1'b0);
        add_req(REQ_ENQ, 32'd12, 16'h0000, 1'b0);
        add_req(REQ_ENQ, 32'd13, 16'h0000, 1'b0);
        add_req(REQ_TRAV,  '0, '0, 1'b0);
        add_req(REQ_QUERY, '0, '0, 1'b0);
        // fill to capacity, overflow once, then list the full queue
        for (int i = 0; i < CAPACITY_DEF - 7; i++)
            add_req(REQ_ENQ, $urandom, 16'($urandom_range(0, 6)) - 16'd3, 1'b0);
        add_req(REQ_ENQ,   32'hDEAD_BEEF, 16'h8000, 1'b0);
        add_req(REQ_TRAV,  '0, '0, 1'b0);
        add_req(REQ_DEQ,   '0, '0, 1'b0);
        add_req(REQ_DEQ,   '0, '0, 1'b0);
        add_req(REQ_QUERY, '0, '0, 1'b0);

        // random part: alternate fill-heavy and drain-heavy stretches
        for (int i = 0; i < RAND_REQS; i++) begin
            fill_phase = ((i / 40) % 2) == 0;
            r = $urandom_range(0, 99);
            if (fill_phase)
                kind = (r < 55) ? REQ_ENQ : (r < 75) ? REQ_DEQ : (r < 88) ? REQ_TRAV
                                                                           : REQ_QUERY;
            else
                kind = (r < 20) ? REQ_ENQ : (r < 70) ? REQ_DEQ : (r < 85) ? REQ_TRAV
                                                                           : REQ_QUERY;
            value = ($urandom_range(0, 9) == 0) ? {$urandom_range(0, 1) == 0, {31{1'b0}}}
                                                : $urandom;
            case ($urandom_range(0, 2))
                0:       prio = 16'($urandom);
                1:       prio = 16'($urandom_range(0, 6)) - 16'd3;   // ties
                default: begin
                    r = $urandom_range(0, 3);
                    prio = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF
                         : (r == 2) ? 16'h0000 : 16'hFFFF;
                end
            endcase
            add_req(kind, value, prio, (i == 150 || i == 250));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(stim_done && results_due == 0))
            @(posedge aclk);
        // let a traverse rotation finish and catch any stray result
        repeat (CAPACITY_DEF + 8) @(posedge aclk);

        $display("Covered %0d requests and %0d results, %0d full and %0d underflow cases.",
                 reqs_accepted, results_seen, full_hits, underflow_hits);
        $display("Enqueue with ties, dequeue, traverse and query from empty to full.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
